[rtl/bawt_pkg.sv]
// Shared types and constants for the block average with trend.
// Field widths, default parameter values and the lane control struct.
// No dependencies.
package bawt_pkg;

  // Sample and average field widths
  localparam int TEMP_W = 15;
  localparam int PRES_W = 17;
  localparam int HUM_W  = 14;

  // Trend field widths
  localparam int TREND_T_W = 15;
  localparam int TREND_P_W = 18;
  localparam int TREND_H_W = 15;

  // Default block size and history depth
  localparam int SAMPLES_PER_BLOCK_DEF = 16;
  localparam int HISTORY_DEPTH_DEF     = 8;

  // Pipeline enables shared by the lanes and the merge stage
  typedef struct packed {
    logic acc_en;    // input beat accepted, accumulate
    logic blk_load;  // last sample of a block accepted, capture block sum
    logic q_load;    // block sum moves into the divide stage
    logic out_load;  // quotients move into the output register
  } ctl_t;

endpackage

[rtl/bawt_ctrl.sv]
// Pipeline control for the block average with trend: sample counter, stage
// occupancy, handshake and the enables for the lanes and merge stage.
// Depends on bawt_pkg.
module bawt_ctrl
  import bawt_pkg::*;
#(
  parameter int SAMPLES_PER_BLOCK = SAMPLES_PER_BLOCK_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  output logic out_valid,
  input  logic out_stall,
  output ctl_t ctl
);

  localparam int IDX_W = $clog2(SAMPLES_PER_BLOCK);

  logic [IDX_W-1:0] sample_index;
  logic             valid_a;
  logic             valid_b;
  logic             last_sample;

  // Stage enables, from the output back to the input
  always_comb begin
    ctl.out_load = valid_b && (!out_valid || !out_stall);
    ctl.q_load   = valid_a && (!valid_b || ctl.out_load);
    in_stall     = valid_a && !ctl.q_load;
    ctl.acc_en   = in_valid && !in_stall;
    last_sample  = (sample_index == IDX_W'(SAMPLES_PER_BLOCK - 1));
    ctl.blk_load = ctl.acc_en && last_sample;
  end

  // Count samples within the block
  always_ff @(posedge clk) begin
    if (rst) begin
      sample_index <= '0;
    end else if (ctl.acc_en) begin
      if (last_sample) begin
        sample_index <= '0;
      end else begin
        sample_index <= sample_index + IDX_W'(1);
      end
    end
  end

  // Track stage occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      valid_a   <= 1'b0;
      valid_b   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (ctl.blk_load) begin
        valid_a <= 1'b1;
      end else if (ctl.q_load) begin
        valid_a <= 1'b0;
      end
      if (ctl.q_load) begin
        valid_b <= 1'b1;
      end else if (ctl.out_load) begin
        valid_b <= 1'b0;
      end
      if (ctl.out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

`ifndef SYNTH
  // A captured block sum is never overwritten before it moves on
  assert property (@(posedge clk) disable iff (rst)
    ctl.blk_load |-> (!valid_a || ctl.q_load))
    else $error("block sum overwritten");

  // A held block sum stays held
  assert property (@(posedge clk) disable iff (rst)
    (valid_a && !ctl.q_load) |=> valid_a)
    else $error("block sum lost");

  // A stalled result stays on offer
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> out_valid)
    else $error("result dropped under stall");

  // The sample counter stays within the block
  assert property (@(posedge clk) disable iff (rst)
    sample_index <= IDX_W'(SAMPLES_PER_BLOCK - 1))
    else $error("sample counter out of range");
`endif

endmodule

[rtl/bawt_lane.sv]
// One channel lane: running sum, block capture and floor division by the
// block size as a multiplication by a reciprocal. Depends on bawt_pkg.
module bawt_lane
  import bawt_pkg::*;
#(
  parameter int SAMPLES_PER_BLOCK = SAMPLES_PER_BLOCK_DEF,
  parameter int IN_W              = TEMP_W,
  parameter bit SIGNED_IN         = 1'b0
) (
  input  logic            clk,
  input  logic            rst,
  input  ctl_t            ctl,
  input  logic [IN_W-1:0] sample,
  output logic [IN_W-1:0] avg
);

  // Signed sums carry a bias of SAMPLES_PER_BLOCK * 2^(IN_W-1) so that the
  // divider only sees non-negative values; the bias divides out exactly.
  localparam int LOG_D = $clog2(SAMPLES_PER_BLOCK);
  localparam int SW    = IN_W + LOG_D;
  localparam int K     = SW + LOG_D;
  localparam int MW    = SW + 1;
  localparam int PW    = SW + MW;
  localparam longint unsigned RECIP =
    ((64'd1 << K) + 64'(SAMPLES_PER_BLOCK) - 64'd1) / 64'(SAMPLES_PER_BLOCK);
  localparam logic [SW-1:0] BIAS =
    SIGNED_IN ? (SW'(SAMPLES_PER_BLOCK) << (IN_W - 1)) : '0;

  logic [SW-1:0]   sum;
  logic [SW-1:0]   blk;
  logic [SW-1:0]   acc_sum;
  logic [SW-1:0]   x_ext;
  logic            ext_bit;
  logic [PW-1:0]   prod;
  logic [IN_W-1:0] quot;

  // Extend the sample and add it to the running sum
  always_comb begin
    ext_bit = SIGNED_IN && sample[IN_W-1];
    x_ext   = {{LOG_D{ext_bit}}, sample};
    acc_sum = sum + x_ext;
  end

  // Accumulate; restart from the bias at the end of each block
  always_ff @(posedge clk) begin
    if (rst) begin
      sum <= BIAS;
    end else if (ctl.acc_en) begin
      if (ctl.blk_load) begin
        sum <= BIAS;
      end else begin
        sum <= acc_sum;
      end
    end
  end

  // Capture the finished block sum
  always_ff @(posedge clk) begin
    if (ctl.blk_load) begin
      blk <= acc_sum;
    end
  end

  // Divide by the block size: multiply by the rounded-up reciprocal
  assign prod = PW'(blk) * PW'(RECIP);

  always_ff @(posedge clk) begin
    if (ctl.q_load) begin
      quot <= prod[K +: IN_W];
    end
  end

  // Remove the bias: for signed lanes it is the top bit of the quotient
  assign avg = quot ^ {SIGNED_IN, {(IN_W - 1){1'b0}}};

endmodule

[rtl/bawt_merge.sv]
// Merge stage: combines the three lane averages with the previous block's
// averages into trends, keeps the history count and holds the result beat.
// Depends on bawt_pkg.
module bawt_merge
  import bawt_pkg::*;
#(
  parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  ctl_t                                   ctl,
  input  logic [TEMP_W-1:0]                      lane_temperature,
  input  logic [PRES_W-1:0]                      lane_pressure,
  input  logic [HUM_W-1:0]                       lane_humidity,
  output logic signed [TEMP_W-1:0]               avg_temperature,
  output logic [PRES_W-1:0]                      avg_pressure,
  output logic [HUM_W-1:0]                       avg_humidity,
  output logic signed [TREND_T_W-1:0]            trend_temperature,
  output logic signed [TREND_P_W-1:0]            trend_pressure,
  output logic signed [TREND_H_W-1:0]            trend_humidity,
  output logic                                   trend_valid,
  output logic [$clog2(HISTORY_DEPTH+1)-1:0]     history_count
);

  localparam int CW = $clog2(HISTORY_DEPTH + 1);

  logic [CW-1:0]          stored_count;
  logic [CW-1:0]          stored_count_next;
  logic                   have_prev;
  logic [TEMP_W-1:0]      last_temperature;
  logic [PRES_W-1:0]      last_pressure;
  logic [HUM_W-1:0]       last_humidity;
  logic [TEMP_W:0]        diff_t;
  logic [PRES_W:0]        diff_p;
  logic [HUM_W:0]         diff_h;
  logic [TREND_T_W-1:0]   trend_t_next;
  logic [TREND_P_W-1:0]   trend_p_next;
  logic [TREND_H_W-1:0]   trend_h_next;

  // Form the trends; temperature saturates to its field
  always_comb begin
    have_prev = (stored_count != '0);
    diff_t = {lane_temperature[TEMP_W-1], lane_temperature}
           - {last_temperature[TEMP_W-1], last_temperature};
    diff_p = {1'b0, lane_pressure} - {1'b0, last_pressure};
    diff_h = {1'b0, lane_humidity} - {1'b0, last_humidity};
    if (!have_prev) begin
      trend_t_next = '0;
      trend_p_next = '0;
      trend_h_next = '0;
    end else begin
      if (diff_t[TEMP_W] != diff_t[TEMP_W-1]) begin
        trend_t_next = {diff_t[TEMP_W], {(TREND_T_W - 1){~diff_t[TEMP_W]}}};
      end else begin
        trend_t_next = diff_t[TREND_T_W-1:0];
      end
      trend_p_next = diff_p;
      trend_h_next = diff_h;
    end
    if (stored_count == CW'(HISTORY_DEPTH)) begin
      stored_count_next = stored_count;
    end else begin
      stored_count_next = stored_count + CW'(1);
    end
  end

  // Saturating history count
  always_ff @(posedge clk) begin
    if (rst) begin
      stored_count <= '0;
    end else if (ctl.out_load) begin
      stored_count <= stored_count_next;
    end
  end

  // Hold the result beat and remember this block's averages
  always_ff @(posedge clk) begin
    if (ctl.out_load) begin
      avg_temperature   <= lane_temperature;
      avg_pressure      <= lane_pressure;
      avg_humidity      <= lane_humidity;
      trend_temperature <= trend_t_next;
      trend_pressure    <= trend_p_next;
      trend_humidity    <= trend_h_next;
      trend_valid       <= have_prev;
      history_count     <= stored_count_next;
      last_temperature  <= lane_temperature;
      last_pressure     <= lane_pressure;
      last_humidity     <= lane_humidity;
    end
  end

endmodule

[rtl/block_average_with_trend.sv]
// Block average with trend: one sample beat per cycle unless the input stalls,
// one result beat per SAMPLES_PER_BLOCK samples. A closed block's result passes
// the capture, divide multiply and merge registers. The input stalls only
// when a captured block, a quotient and a waiting result are all held.
// Reset clears the sums, sample counter and history count; no clearing pass.
// Depends on bawt_pkg, bawt_ctrl, bawt_lane and bawt_merge.
module block_average_with_trend
  import bawt_pkg::*;
#(
  parameter int SAMPLES_PER_BLOCK = SAMPLES_PER_BLOCK_DEF,
  parameter int HISTORY_DEPTH     = HISTORY_DEPTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic signed [TEMP_W-1:0]           temperature,
  input  logic [PRES_W-1:0]                  pressure,
  input  logic [HUM_W-1:0]                   humidity,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [TEMP_W-1:0]           avg_temperature,
  output logic [PRES_W-1:0]                  avg_pressure,
  output logic [HUM_W-1:0]                   avg_humidity,
  output logic signed [TREND_T_W-1:0]        trend_temperature,
  output logic signed [TREND_P_W-1:0]        trend_pressure,
  output logic signed [TREND_H_W-1:0]        trend_humidity,
  output logic                               trend_valid,
  output logic [$clog2(HISTORY_DEPTH+1)-1:0] history_count
);

  ctl_t              ctl;
  logic [TEMP_W-1:0] lane_temperature;
  logic [PRES_W-1:0] lane_pressure;
  logic [HUM_W-1:0]  lane_humidity;

  // Handshake and stage enables
  bawt_ctrl #(
    .SAMPLES_PER_BLOCK(SAMPLES_PER_BLOCK)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .ctl      (ctl)
  );

  // One lane per channel
  bawt_lane #(
    .SAMPLES_PER_BLOCK(SAMPLES_PER_BLOCK),
    .IN_W             (TEMP_W),
    .SIGNED_IN        (1'b1)
  ) u_lane_temperature (
    .clk   (clk),
    .rst   (rst),
    .ctl   (ctl),
    .sample(temperature),
    .avg   (lane_temperature)
  );

  bawt_lane #(
    .SAMPLES_PER_BLOCK(SAMPLES_PER_BLOCK),
    .IN_W             (PRES_W),
    .SIGNED_IN        (1'b0)
  ) u_lane_pressure (
    .clk   (clk),
    .rst   (rst),
    .ctl   (ctl),
    .sample(pressure),
    .avg   (lane_pressure)
  );

  bawt_lane #(
    .SAMPLES_PER_BLOCK(SAMPLES_PER_BLOCK),
    .IN_W             (HUM_W),
    .SIGNED_IN        (1'b0)
  ) u_lane_humidity (
    .clk   (clk),
    .rst   (rst),
    .ctl   (ctl),
    .sample(humidity),
    .avg   (lane_humidity)
  );

  // Trends, history count and the result register
  bawt_merge #(
    .HISTORY_DEPTH(HISTORY_DEPTH)
  ) u_merge (
    .clk              (clk),
    .rst              (rst),
    .ctl              (ctl),
    .lane_temperature (lane_temperature),
    .lane_pressure    (lane_pressure),
    .lane_humidity    (lane_humidity),
    .avg_temperature  (avg_temperature),
    .avg_pressure     (avg_pressure),
    .avg_humidity     (avg_humidity),
    .trend_temperature(trend_temperature),
    .trend_pressure   (trend_pressure),
    .trend_humidity   (trend_humidity),
    .trend_valid      (trend_valid),
    .history_count    (history_count)
  );

endmodule

[bench/bawt_checker.sv]
`timescale 1ns / 100ps
// Checker for block_average_with_trend: watches the sample and result channels.
// Predicts every block result and compares it field by field; uses bawt_pkg.
module bawt_checker
  import bawt_pkg::*;
#(
  parameter int SAMPLES_PER_BLOCK = SAMPLES_PER_BLOCK_DEF,
  parameter int HISTORY_DEPTH     = HISTORY_DEPTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  input  logic                               in_stall,
  input  logic signed [TEMP_W-1:0]           temperature,
  input  logic [PRES_W-1:0]                  pressure,
  input  logic [HUM_W-1:0]                   humidity,
  input  logic                               out_valid,
  input  logic                               out_stall,
  input  logic signed [TEMP_W-1:0]           avg_temperature,
  input  logic [PRES_W-1:0]                  avg_pressure,
  input  logic [HUM_W-1:0]                   avg_humidity,
  input  logic signed [TREND_T_W-1:0]        trend_temperature,
  input  logic signed [TREND_P_W-1:0]        trend_pressure,
  input  logic signed [TREND_H_W-1:0]        trend_humidity,
  input  logic                               trend_valid,
  input  logic [$clog2(HISTORY_DEPTH+1)-1:0] history_count,
  output int                                 fail_count,
  output int                                 pending
);

  localparam int CNT_W = $clog2(HISTORY_DEPTH + 1);

  typedef struct {
    logic signed [TEMP_W-1:0]    avg_t;
    logic [PRES_W-1:0]           avg_p;
    logic [HUM_W-1:0]            avg_h;
    logic signed [TREND_T_W-1:0] trend_t;
    logic signed [TREND_P_W-1:0] trend_p;
    logic signed [TREND_H_W-1:0] trend_h;
    logic                        trend_ok;
    logic [CNT_W-1:0]            count;
  } block_result_t;

  block_result_t block_results_q[$];

  // running block state
  int sum_t, sum_p, sum_h;
  int samples_taken;
  int prev_t, prev_p, prev_h;
  int averages_held;
  int mismatches;

  initial begin
    fail_count = 0;
    pending    = 0;
    mismatches = 0;
  end

  // floor division by the block size, also for negative sums
  function automatic int floor_avg(int total);
    int q;
    q = total / SAMPLES_PER_BLOCK;
    if ((total % SAMPLES_PER_BLOCK) != 0 && total < 0) q = q - 1;
    return q;
  endfunction

  function automatic int clamp(int v, int lo, int hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  // add one sample beat; close the block and queue its result when full
  task automatic take_sample(int t, int p, int h);
    block_result_t r;
    int at, ap, ah;
    sum_t = sum_t + t;
    sum_p = sum_p + p;
    sum_h = sum_h + h;
    samples_taken++;
    if (samples_taken == SAMPLES_PER_BLOCK) begin
      at = floor_avg(sum_t);
      ap = floor_avg(sum_p);
      ah = floor_avg(sum_h);
      r.avg_t    = at;
      r.avg_p    = ap;
      r.avg_h    = ah;
      r.trend_ok = averages_held > 0;
      r.trend_t  = 0;
      r.trend_p  = 0;
      r.trend_h  = 0;
      if (r.trend_ok) begin
        r.trend_t = clamp(at - prev_t, -16384, 16383);
        r.trend_p = clamp(ap - prev_p, -131072, 131071);
        r.trend_h = clamp(ah - prev_h, -16384, 16383);
      end
      if (averages_held < HISTORY_DEPTH) averages_held++;
      r.count = averages_held;
      prev_t = at;
      prev_p = ap;
      prev_h = ah;
      sum_t = 0;
      sum_p = 0;
      sum_h = 0;
      samples_taken = 0;
      block_results_q.push_back(r);
    end
  endtask

  task automatic compare_field(string what, int want, int got);
    if (want != got) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: %s mismatch, expected %0d, got %0d", $realtime, what, want, got);
    end
  endtask

  // match a result beat against the oldest queued block result
  task automatic check_result();
    block_result_t w;
    if (block_results_q.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: result beat with no block result outstanding", $realtime);
    end else begin
      w = block_results_q.pop_front();
      compare_field("avg_temperature", w.avg_t, avg_temperature);
      compare_field("avg_pressure", w.avg_p, avg_pressure);
      compare_field("avg_humidity", w.avg_h, avg_humidity);
      compare_field("trend_temperature", w.trend_t, trend_temperature);
      compare_field("trend_pressure", w.trend_p, trend_pressure);
      compare_field("trend_humidity", w.trend_h, trend_humidity);
      compare_field("trend_valid", w.trend_ok, trend_valid);
      compare_field("history_count", w.count, history_count);
    end
  endtask

  // sample both channels at the edge where the beats move
  always @(posedge clk) begin
    if (rst) begin
      sum_t = 0;
      sum_p = 0;
      sum_h = 0;
      samples_taken = 0;
      prev_t = 0;
      prev_p = 0;
      prev_h = 0;
      averages_held = 0;
      block_results_q.delete();
    end else begin
      if (in_valid && !in_stall) take_sample(temperature, pressure, humidity);
      if (out_valid && !out_stall) check_result();
    end
    pending    <= block_results_q.size();
    fail_count <= mismatches;
  end

endmodule

[bench/testbench.sv]
`timescale 1ns / 100ps
// Top of the block_average_with_trend bench: clock, reset, sample stimulus,
// result-side stalls and the verdict. Depends on bawt_pkg and bawt_checker.
module testbench;
  import bawt_pkg::*;

  localparam int SAMPLES_PER_BLOCK = SAMPLES_PER_BLOCK_DEF;
  localparam int HISTORY_DEPTH     = HISTORY_DEPTH_DEF;
  localparam int RANDOM_ITEMS      = 500;

  // shapes of sample content, chosen per block
  typedef enum int {
    MIX_RAW,
    MIX_SPAN,
    MIX_LOW,
    MIX_HIGH,
    MIX_NEAR_ZERO,
    MIX_EDGES
  } mix_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [TEMP_W-1:0] temperature = '0;
  logic [PRES_W-1:0] pressure = '0;
  logic [HUM_W-1:0] humidity = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [TEMP_W-1:0] avg_temperature;
  logic [PRES_W-1:0] avg_pressure;
  logic [HUM_W-1:0] avg_humidity;
  logic signed [TREND_T_W-1:0] trend_temperature;
  logic signed [TREND_P_W-1:0] trend_pressure;
  logic signed [TREND_H_W-1:0] trend_humidity;
  logic trend_valid;
  logic [$clog2(HISTORY_DEPTH+1)-1:0] history_count;
  int fail_count;
  int pending;

  int burst_left = 0;
  int stall_window = 0;
  int stall_mode = 0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  block_average_with_trend #(
    .SAMPLES_PER_BLOCK(SAMPLES_PER_BLOCK),
    .HISTORY_DEPTH    (HISTORY_DEPTH)
  ) u_dut (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .temperature      (temperature),
    .pressure         (pressure),
    .humidity         (humidity),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .avg_temperature  (avg_temperature),
    .avg_pressure     (avg_pressure),
    .avg_humidity     (avg_humidity),
    .trend_temperature(trend_temperature),
    .trend_pressure   (trend_pressure),
    .trend_humidity   (trend_humidity),
    .trend_valid      (trend_valid),
    .history_count    (history_count)
  );

  bawt_checker #(
    .SAMPLES_PER_BLOCK(SAMPLES_PER_BLOCK),
    .HISTORY_DEPTH    (HISTORY_DEPTH)
  ) u_checker (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .temperature      (temperature),
    .pressure         (pressure),
    .humidity         (humidity),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .avg_temperature  (avg_temperature),
    .avg_pressure     (avg_pressure),
    .avg_humidity     (avg_humidity),
    .trend_temperature(trend_temperature),
    .trend_pressure   (trend_pressure),
    .trend_humidity   (trend_humidity),
    .trend_valid      (trend_valid),
    .history_count    (history_count),
    .fail_count       (fail_count),
    .pending          (pending)
  );

  // stall the result side in windows: free flow, light, heavy or solid
  always @(posedge clk) begin
    if (stall_window == 0) begin
      stall_mode   <= $urandom_range(0, 3);
      stall_window <= $urandom_range(16, 80);
    end else begin
      stall_window <= stall_window - 1;
    end
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= $urandom_range(0, 1);
      2: out_stall <= ($urandom_range(0, 3) != 0);
      default: out_stall <= 1'b1;
    endcase
  end

  // offer one sample beat, idling between bursts, and hold it until taken
  task automatic send_sample(int t, int p, int h);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 12);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                                : $urandom_range(1, 16);
    end
    burst_left--;
    in_valid    <= 1'b1;
    temperature <= t;
    pressure    <= p;
    humidity    <= h;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // hold the sample side until every queued block result has come out
  task automatic drain_results();
    in_valid   <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin
    int t, p, h;
    mix_t mix;
    mix = MIX_LOW;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // first block: raw minimum temperature, full pressure, no previous average
    repeat (SAMPLES_PER_BLOCK) send_sample(-16384, 131071, 0);
    // second block: climb to raw maximum, temperature trend saturates high
    repeat (SAMPLES_PER_BLOCK) send_sample(16383, 0, 16383);
    drain_results();

    // random blocks; the first falls back to the minimum so the trend saturates low
    for (int k = 0; k < RANDOM_ITEMS; k++) begin
      if (k % SAMPLES_PER_BLOCK == 0)
        mix = (k == 0) ? MIX_LOW : mix_t'($urandom_range(0, 5));
      if (k == RANDOM_ITEMS / 2) drain_results();
      case (mix)
        MIX_RAW: begin
          t = $urandom_range(0, 32767);
          p = $urandom_range(0, 131071);
          h = $urandom_range(0, 16383);
        end
        MIX_SPAN: begin
          t = $urandom_range(0, 12500) - 4000;
          p = $urandom_range(0, 131071);
          h = $urandom_range(0, 10000);
        end
        MIX_LOW: begin
          t = -16384;
          p = $urandom_range(0, 3);
          h = $urandom_range(0, 3);
        end
        MIX_HIGH: begin
          t = 16383;
          p = 131071;
          h = 16383;
        end
        MIX_NEAR_ZERO: begin
          t = int'($urandom_range(0, 40)) - 20;
          p = $urandom_range(0, 31);
          h = $urandom_range(0, 31);
        end
        default: begin
          t = $urandom_range(0, 1) ? 8500 : -4000;
          p = $urandom_range(0, 1) ? 131071 : 0;
          h = $urandom_range(0, 1) ? 10000 : 0;
        end
      endcase
      send_sample(t, p, h);
    end

    // let the last results out, then allow for any stray beat
    drain_results();
    repeat (10) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("block_average_with_trend verification clean");
    end else begin
      $display("block_average_with_trend verification failed");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2_000_000;
    $display("block_average_with_trend verification failed");
    $finish;
  end

endmodule
